// ===== rtl/dcse_pkg.sv =====
// Package for the density column span extractor.
// Field widths, register codes and fixed constants; no dependencies.
package dcse_pkg;

  localparam int DENS_W   = 16;  // density sample width (signed)
  localparam int HEIGHT_W = 22;  // span height width, 1/256 world units
  localparam int CELL_W   = 16;  // cell size, Q8.8
  localparam int CH_W     = 7;   // cells_high register width
  localparam int IDX_W    = 7;   // corner index width
  localparam int FRAC_W   = 9;   // crossing fraction, 0..256
  localparam int MAG_W    = 16;  // |density|
  localparam int SUM_W    = 17;  // |lower| + |upper|
  localparam int REM_W    = 18;  // divider partial remainder
  localparam int MUL_A_W  = 15;  // multiplier operand A
  localparam int PROD_W   = MUL_A_W + CELL_W;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};
  localparam logic [IDX_W-1:0]    IDX_MAX    = {IDX_W{1'b1}};

  localparam logic [CELL_W-1:0] CELL_SIZE_RST  = 16'd256;
  localparam logic [CH_W-1:0]   CELLS_HIGH_RST = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_SIZE  = 1'b0,
    REG_CELLS_HIGH = 1'b1
  } cfg_reg_e;

endpackage

// ===== rtl/dcse_in_if.sv =====
// Input channel of the density column span extractor: one density sample.
// Depends on dcse_pkg.
interface dcse_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [dcse_pkg::DENS_W-1:0] density;
  logic                               column_last;

  modport source (output valid, output density, output column_last, input ready);
  modport sink   (input valid, input density, input column_last, output ready);
endinterface

// ===== rtl/dcse_out_if.sv =====
// Output channel of the density column span extractor: one span result.
// Depends on dcse_pkg.
interface dcse_out_if;
  logic                          valid;
  logic                          ready;
  logic                          span_valid;
  logic [dcse_pkg::HEIGHT_W-1:0] span_bottom;
  logic [dcse_pkg::HEIGHT_W-1:0] span_top;
  logic                          column_done;

  modport source (output valid, output span_valid, output span_bottom,
                  output span_top, output column_done, input ready);
  modport sink   (input valid, input span_valid, input span_bottom,
                  input span_top, input column_done, output ready);
endinterface

// ===== rtl/density_column_span_extract_top.sv =====
// Density column span extractor, top level.
// Depends on dcse_pkg, dcse_in_if and dcse_out_if.
//
//  Channel   Dir  Handshake     Transaction payload
//  --------  ---  ------------  -----------------------------------------------
//  in_i      in   valid/ready   density (s16), column_last
//  out_o     out  valid/ready   span_valid, span_bottom, span_top, column_done
//  cfg       in   cfg_we_i      cfg_idx_i: 0 = cell_size, 1 = cells_high
//
// Sequence: a sample passes the ceiling product, its saturation and the final
//   step before the next is taken; with a solid/air change above corner 0 it
//   also passes the radix-2 restoring divider for the 9-bit crossing fraction.
// One 15x16 multiplier is shared between the ceiling (cells * cell_size) and
//   the crossing height (((corner-1)*256 + frac) * cell_size); each product is
//   registered and saturated in the following cycle.
// Reset clears column state and loads cell_size = 256, cells_high = 64.
// Stalls: the result sits in an output register; the sequencer only waits in
//   its final step when a new result is due and the previous one is unclaimed.
module density_column_span_extract_top #(
  parameter int MAX_CELLS_HIGH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dcse_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [dcse_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  dcse_in_if.sink                             in_i,
  dcse_out_if.source                          out_o
);

  localparam int NW = $clog2(MAX_CELLS_HIGH + 1);

  // one-hot sequencer
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,  // waiting for a sample
    ST_CMUL = 7'b0000010,  // ceiling product, divider setup
    ST_CSAT = 7'b0000100,  // ceiling saturation
    ST_DIV  = 7'b0001000,  // one quotient bit per cycle
    ST_XMUL = 7'b0010000,  // crossing height product
    ST_XSAT = 7'b0100000,  // clamp crossing to ceiling
    ST_FIN  = 7'b1000000   // update run state, load result
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [dcse_pkg::CELL_W-1:0] cell_size_q;
  logic [dcse_pkg::CH_W-1:0]   cells_high_q;

  // captured sample
  logic signed [dcse_pkg::DENS_W-1:0] density_q;
  logic                               last_q;

  // column state
  logic                                inside_q, inside_d;
  logic [dcse_pkg::HEIGHT_W-1:0]       run_bottom_q, run_bottom_d;
  logic signed [dcse_pkg::DENS_W-1:0]  prev_q, prev_d;
  logic [dcse_pkg::IDX_W-1:0]          corner_q, corner_d;

  // datapath
  logic [dcse_pkg::REM_W-1:0]    rem_q, rem_d;
  logic [dcse_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [dcse_pkg::FRAC_W-1:0]   quot_q, quot_d;
  logic [3:0]                    cnt_q, cnt_d;
  logic [dcse_pkg::PROD_W-1:0]   prod_q, prod_d;
  logic [dcse_pkg::HEIGHT_W-1:0] ceil_q, ceil_d;
  logic [dcse_pkg::HEIGHT_W-1:0] height_q, height_d;

  // result register
  logic                          out_valid_q, out_valid_d;
  logic                          res_span_q, res_span_d;
  logic [dcse_pkg::HEIGHT_W-1:0] res_bottom_q, res_bottom_d;
  logic [dcse_pkg::HEIGHT_W-1:0] res_top_q, res_top_d;
  logic                          res_done_q, res_done_d;

  function automatic logic [dcse_pkg::MAG_W-1:0] mag(
    input logic signed [dcse_pkg::DENS_W-1:0] v
  );
    logic [dcse_pkg::MAG_W-1:0] u;
    u = v;
    return v[dcse_pkg::DENS_W-1] ? (~u + 1'b1) : u;
  endfunction

  // clamped cell count for the ceiling
  logic [NW-1:0] n_cells;
  always_comb begin
    if (cells_high_q == '0) begin
      n_cells = NW'(1);
    end else if (int'(cells_high_q) > MAX_CELLS_HIGH) begin
      n_cells = NW'(MAX_CELLS_HIGH);
    end else begin
      n_cells = NW'(cells_high_q);
    end
  end

  // sample classification
  logic solid, open_run, close_run, need_cross;
  assign solid      = density_q > 16'sd0;
  assign open_run   = solid & ~inside_q;
  assign close_run  = ~solid & inside_q;
  assign need_cross = (open_run | close_run) && (corner_q != '0);

  // shared multiplier
  logic [dcse_pkg::MUL_A_W-1:0]  mul_a;
  logic [dcse_pkg::FRAC_W-1:0]   frac;
  logic [dcse_pkg::MUL_A_W-1:0]  corner_base;
  assign frac        = (sum_q == '0) ? '0 : quot_q;
  assign corner_base = {corner_q - 7'd1, 8'd0};
  assign mul_a = (state_q == ST_CMUL) ? dcse_pkg::MUL_A_W'(n_cells)
                                      : corner_base + dcse_pkg::MUL_A_W'(frac);

  // divider step
  logic                       div_ge;
  logic [dcse_pkg::REM_W-1:0] div_rem;
  assign div_ge  = rem_q >= dcse_pkg::REM_W'(sum_q);
  assign div_rem = div_ge ? rem_q - dcse_pkg::REM_W'(sum_q) : rem_q;

  // final-step result
  logic                          fin_inside, fin_emit, fin_produce, fin_go;
  logic [dcse_pkg::HEIGHT_W-1:0] fin_bottom, fin_top, cross_h;
  assign cross_h     = (corner_q == '0) ? '0 : height_q;
  assign fin_inside  = open_run | (inside_q & ~close_run);
  assign fin_bottom  = open_run ? cross_h : run_bottom_q;
  assign fin_emit    = close_run | (last_q & fin_inside);
  assign fin_top     = (last_q & fin_inside) ? ceil_q : cross_h;
  assign fin_produce = fin_emit | last_q;
  assign fin_go      = ~fin_produce | ~out_valid_q | out_o.ready;

  always_comb begin
    state_d      = state_q;
    inside_d     = inside_q;
    run_bottom_d = run_bottom_q;
    prev_d       = prev_q;
    corner_d     = corner_q;
    rem_d        = rem_q;
    sum_d        = sum_q;
    quot_d       = quot_q;
    cnt_d        = cnt_q;
    prod_d       = prod_q;
    ceil_d       = ceil_q;
    height_d     = height_q;
    out_valid_d  = out_valid_q & ~out_o.ready;
    res_span_d   = res_span_q;
    res_bottom_d = res_bottom_q;
    res_top_d    = res_top_q;
    res_done_d   = res_done_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_CMUL;
        end
      end
      ST_CMUL: begin
        prod_d  = mul_a * cell_size_q;
        rem_d   = dcse_pkg::REM_W'(mag(prev_q));
        sum_d   = dcse_pkg::SUM_W'(mag(prev_q)) + dcse_pkg::SUM_W'(mag(density_q));
        quot_d  = '0;
        cnt_d   = '0;
        state_d = ST_CSAT;
      end
      ST_CSAT: begin
        ceil_d  = (prod_q > dcse_pkg::PROD_W'(dcse_pkg::HEIGHT_MAX)) ? dcse_pkg::HEIGHT_MAX
                                                                 : prod_q[dcse_pkg::HEIGHT_W-1:0];
        state_d = need_cross ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        quot_d = {quot_q[dcse_pkg::FRAC_W-2:0], div_ge};
        rem_d  = {div_rem[dcse_pkg::REM_W-2:0], 1'b0};
        cnt_d  = cnt_q + 4'd1;
        if (cnt_q == 4'(dcse_pkg::FRAC_W - 1)) begin
          state_d = ST_XMUL;
        end
      end
      ST_XMUL: begin
        prod_d  = mul_a * cell_size_q;
        state_d = ST_XSAT;
      end
      ST_XSAT: begin
        // height = product / 256, never above the ceiling
        if (prod_q[dcse_pkg::PROD_W-1:8] > 23'(ceil_q)) begin
          height_d = ceil_q;
        end else begin
          height_d = prod_q[dcse_pkg::HEIGHT_W+7:8];
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          if (fin_produce) begin
            out_valid_d  = 1'b1;
            res_span_d   = fin_emit;
            res_bottom_d = fin_emit ? fin_bottom : '0;
            res_top_d    = fin_emit ? fin_top : '0;
            res_done_d   = last_q;
          end
          if (last_q) begin
            inside_d     = 1'b0;
            run_bottom_d = '0;
            prev_d       = '0;
            corner_d     = '0;
          end else begin
            inside_d     = fin_inside;
            run_bottom_d = fin_bottom;
            prev_d       = density_q;
            if (corner_q != dcse_pkg::IDX_MAX) begin
              corner_d = corner_q + 7'd1;
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  assign out_o.valid       = out_valid_q;
  assign out_o.span_valid  = res_span_q;
  assign out_o.span_bottom = res_bottom_q;
  assign out_o.span_top    = res_top_q;
  assign out_o.column_done = res_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cell_size_q  <= dcse_pkg::CELL_SIZE_RST;
      cells_high_q <= dcse_pkg::CELLS_HIGH_RST;
      inside_q     <= 1'b0;
      run_bottom_q <= '0;
      prev_q       <= '0;
      corner_q     <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      inside_q     <= inside_d;
      run_bottom_q <= run_bottom_d;
      prev_q       <= prev_d;
      corner_q     <= corner_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (dcse_pkg::cfg_reg_e'(cfg_idx_i))
          dcse_pkg::REG_CELL_SIZE:  cell_size_q  <= cfg_wdata_i;
          dcse_pkg::REG_CELLS_HIGH: cells_high_q <= cfg_wdata_i[dcse_pkg::CH_W-1:0];
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      density_q <= in_i.density;
      last_q    <= in_i.column_last;
    end
    rem_q        <= rem_d;
    sum_q        <= sum_d;
    quot_q       <= quot_d;
    prod_q       <= prod_d;
    ceil_q       <= ceil_d;
    height_q     <= height_d;
    res_span_q   <= res_span_d;
    res_bottom_q <= res_bottom_d;
    res_top_q    <= res_top_d;
    res_done_q   <= res_done_d;
  end

`ifndef ASSERT_OFF
  // a result without a span is only ever the column-end marker
  a_nospan_is_colend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_span_q |-> res_done_q)
    else $error("span-less result without column_done");

  // an accepted sample always starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == ST_CMUL)
    else $error("accepted sample did not start the sequencer");

  // divider never runs past the last quotient bit
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q < 4'(dcse_pkg::FRAC_W))
    else $error("divider step count out of range");

  // column end leaves the column state cleared
  a_colend_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && fin_go && last_q |=> corner_q == '0 && !inside_q)
    else $error("column state not cleared at column end");
`endif

endmodule

// ===== tb/sv/tb_density_column_span_extract_top.sv =====
// Testbench for density_column_span_extract_top: feeds density columns and
// checks every span result against an in-bench column predictor.
// Depends on dcse_pkg, dcse_in_if, dcse_out_if and the top level RTL.
module tb_density_column_span_extract_top;

  localparam int MAX_CELLS   = 64;
  localparam int IDLE_PCT    = 24;      // idle cycles per hundred, each side
  localparam int SETTLE      = 24;      // wait for a sample still in flight
  localparam int TAIL        = 40;
  localparam int PHASE_ITEMS = 125;
  localparam int CYCLE_LIMIT = 500000;
  localparam int N_PHASES    = 6;

  localparam logic [dcse_pkg::DENS_W-1:0] DENS_MIN  = 16'h8000;
  localparam logic [dcse_pkg::DENS_W-1:0] DENS_MAX  = 16'h7fff;
  localparam logic [dcse_pkg::DENS_W-1:0] DENS_ZERO = 16'h0000;
  localparam logic [dcse_pkg::DENS_W-1:0] DENS_ONE  = 16'h0001;
  localparam logic [dcse_pkg::DENS_W-1:0] DENS_NEG1 = 16'hffff;

  typedef struct packed {
    logic [dcse_pkg::DENS_W-1:0] density;
    logic                        column_last;
  } sample_t;

  typedef struct packed {
    logic                          span_valid;
    logic [dcse_pkg::HEIGHT_W-1:0] span_bottom;
    logic [dcse_pkg::HEIGHT_W-1:0] span_top;
    logic                          column_done;
  } span_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [dcse_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [dcse_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  dcse_in_if  in_if ();
  dcse_out_if out_if ();

  density_column_span_extract_top #(
    .MAX_CELLS_HIGH(MAX_CELLS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Stimulus and scoreboard storage
  sample_t pending_samples[$];
  span_t   expected_spans[$];
  int      pushed_cnt;
  int      accepted_cnt;
  int      fail_cnt;
  int      cycle_cnt;
  logic    in_fire;   // input transaction at the last rising edge
  logic    calm;      // no idling on either side while set

  // Predictor copy of the registers and of the column state
  logic [dcse_pkg::CELL_W-1:0]   cur_cell_size;
  logic [dcse_pkg::CH_W-1:0]     cur_cells_high;
  logic                          col_in_run;
  logic [dcse_pkg::HEIGHT_W-1:0] col_run_bottom;
  logic [dcse_pkg::DENS_W-1:0]   col_prev_density;
  logic [dcse_pkg::IDX_W-1:0]    col_corner;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Column predictor
  // ---------------------------------------------------------------------------

  // cells_high as the ceiling sees it: clamped to 1..MAX_CELLS
  function automatic int clamped_cells();
    int n;
    n = int'(cur_cells_high);
    if (n < 1) n = 1;
    if (n > MAX_CELLS) n = MAX_CELLS;
    return n;
  endfunction

  function automatic logic [dcse_pkg::HEIGHT_W-1:0] ceiling_height();
    logic [63:0] h;
    h = 64'(clamped_cells()) * 64'(cur_cell_size);
    if (h > 64'(dcse_pkg::HEIGHT_MAX)) h = 64'(dcse_pkg::HEIGHT_MAX);
    return h[dcse_pkg::HEIGHT_W-1:0];
  endfunction

  // Linear zero crossing between corner idx (lower) and idx+1 (upper).
  function automatic logic [dcse_pkg::HEIGHT_W-1:0] crossing_height(
    logic [dcse_pkg::IDX_W-1:0]  idx,
    logic [dcse_pkg::DENS_W-1:0] lower,
    logic [dcse_pkg::DENS_W-1:0] upper
  );
    logic [63:0] mag_lo;
    logic [63:0] mag_hi;
    logic [63:0] frac;
    logic [63:0] h;
    logic [dcse_pkg::HEIGHT_W-1:0] ceil_h;
    mag_lo = 64'(lower[dcse_pkg::DENS_W-1] ? -int'($signed(lower)) : int'($signed(lower)));
    mag_hi = 64'(upper[dcse_pkg::DENS_W-1] ? -int'($signed(upper)) : int'($signed(upper)));
    frac = (mag_lo + mag_hi == 0) ? 64'd0 : (mag_lo * 256) / (mag_lo + mag_hi);
    h = ((64'(idx) * 256 + frac) * 64'(cur_cell_size)) >> 8;
    ceil_h = ceiling_height();
    if (h > 64'(ceil_h)) h = 64'(ceil_h);
    return h[dcse_pkg::HEIGHT_W-1:0];
  endfunction

  // Advance the column by one sample; returns 1 when a result is due.
  function automatic logic column_step(sample_t s, output span_t r);
    logic                          solid;
    logic                          emit;
    logic [dcse_pkg::HEIGHT_W-1:0] bot;
    logic [dcse_pkg::HEIGHT_W-1:0] top;
    solid = $signed(s.density) > 0;
    emit  = 1'b0;
    bot   = '0;
    top   = '0;
    if (solid && !col_in_run) begin
      col_in_run     = 1'b1;
      col_run_bottom = (col_corner == 0) ? '0 :
                       crossing_height(col_corner - 1'b1, col_prev_density, s.density);
    end else if (!solid && col_in_run) begin
      col_in_run = 1'b0;
      emit       = 1'b1;
      bot        = col_run_bottom;
      top        = (col_corner == 0) ? '0 :
                   crossing_height(col_corner - 1'b1, col_prev_density, s.density);
    end
    // open run at the column top is capped at the ceiling
    if (s.column_last && col_in_run) begin
      emit = 1'b1;
      bot  = col_run_bottom;
      top  = ceiling_height();
    end
    r.span_valid  = emit;
    r.span_bottom = emit ? bot : '0;
    r.span_top    = emit ? top : '0;
    r.column_done = s.column_last;
    if (s.column_last) begin
      col_in_run       = 1'b0;
      col_run_bottom   = '0;
      col_prev_density = '0;
      col_corner       = '0;
    end else begin
      col_prev_density = s.density;
      if (col_corner != dcse_pkg::IDX_MAX) col_corner = col_corner + 1'b1;
    end
    return emit || s.column_last;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: changes on the falling edge, holds an item until accepted
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic    nxt_valid;
    sample_t nxt_item;
    nxt_valid = in_if.valid && !in_fire;
    nxt_item  = '{density: in_if.density, column_last: in_if.column_last};
    if (!nxt_valid) begin
      // idle bus carries junk so nothing keys off stale payload
      nxt_item = '{density: dcse_pkg::DENS_W'($urandom), column_last: 1'($urandom)};
      if (rst_ni && pending_samples.size() != 0 &&
          (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt_item  = pending_samples.pop_front();
        nxt_valid = 1'b1;
      end
    end
    in_if.valid       <= nxt_valid;
    in_if.density     <= nxt_item.density;
    in_if.column_last <= nxt_item.column_last;
  end

  // Result side back-pressure
  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    span_t got;
    span_t want;
    span_t pred;
    in_fire = 1'b0;
    if (rst_ni) begin
      // compare the result first: it can never stem from this edge's sample
      if (out_if.valid && out_if.ready) begin
        got = '{span_valid: out_if.span_valid, span_bottom: out_if.span_bottom,
                span_top: out_if.span_top, column_done: out_if.column_done};
        if (expected_spans.size() == 0) begin
          $error("unexpected result transaction: valid %0b bottom %0d top %0d done %0b",
                 got.span_valid, got.span_bottom, got.span_top, got.column_done);
          fail_cnt++;
        end else begin
          want = expected_spans.pop_front();
          if (got.span_valid !== want.span_valid) begin
            $error("span_valid: expected %0b, got %0b", want.span_valid, got.span_valid);
            fail_cnt++;
          end
          if (got.span_bottom !== want.span_bottom) begin
            $error("span_bottom: expected %0d, got %0d", want.span_bottom, got.span_bottom);
            fail_cnt++;
          end
          if (got.span_top !== want.span_top) begin
            $error("span_top: expected %0d, got %0d", want.span_top, got.span_top);
            fail_cnt++;
          end
          if (got.column_done !== want.column_done) begin
            $error("column_done: expected %0b, got %0b", want.column_done, got.column_done);
            fail_cnt++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        in_fire = 1'b1;
        accepted_cnt++;
        if (column_step('{density: in_if.density, column_last: in_if.column_last}, pred))
          expected_spans.insert(expected_spans.size(), pred);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_sample(logic [dcse_pkg::DENS_W-1:0] d, logic last);
    pending_samples.insert(pending_samples.size(), '{density: d, column_last: last});
    pushed_cnt++;
  endtask

  // Block is idle once every sample is taken and every result claimed; a
  // sample without a result may still be in flight, hence the settle time.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_cnt != pushed_cnt || expected_spans.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(dcse_pkg::cfg_reg_e idx, logic [dcse_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      dcse_pkg::REG_CELL_SIZE:  cur_cell_size  = val[dcse_pkg::CELL_W-1:0];
      dcse_pkg::REG_CELLS_HIGH: cur_cells_high = val[dcse_pkg::CH_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // style 0: terrain-like (solid low, air high), 1: full-range noise,
  // 2: small values around zero, 3: field extremes
  function automatic logic [dcse_pkg::DENS_W-1:0] pick_density(int pos, int len, int style);
    int v;
    case (style)
      0: v = (len / 2 - pos) * int'($urandom_range(1, 2000)) +
             int'($urandom_range(0, 1200)) - 600;
      1: v = $signed(dcse_pkg::DENS_W'($urandom));
      2: v = int'($urandom_range(0, 600)) - 300;
      default: begin
        case ($urandom_range(4))
          0: return DENS_MIN;
          1: return DENS_MAX;
          2: return DENS_ZERO;
          3: return DENS_ONE;
          default: return DENS_NEG1;
        endcase
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return dcse_pkg::DENS_W'(v);
  endfunction

  task automatic queue_column(int len);
    int style;
    int r;
    r = $urandom_range(9);
    style = (r < 5) ? 0 : (r < 7) ? 2 : (r < 9) ? 1 : 3;
    for (int i = 0; i < len; i++)
      push_sample(pick_density(i, len, style), i == len - 1);
  endtask

  // Mostly full-height columns; some short ones and a few that overrun the
  // grid so the corner index and the ceiling clamp get exercised.
  task automatic random_columns(int n_items);
    int start;
    int len;
    int r;
    start = pushed_cnt;
    while (pushed_cnt - start < n_items) begin
      r = $urandom_range(19);
      if (r < 3)       len = $urandom_range(1, 4);
      else if (r == 3) len = $urandom_range(clamped_cells() + 2, 140);
      else             len = clamped_cells() + 1;
      queue_column(len);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  logic [dcse_pkg::CELL_W-1:0] phase_cell[N_PHASES];
  logic [dcse_pkg::CH_W-1:0]   phase_cells[N_PHASES];

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = dcse_pkg::REG_CELL_SIZE;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.density     = '0;
    in_if.column_last = 1'b0;
    out_if.ready      = 1'b0;
    in_fire           = 1'b0;
    calm              = 1'b0;
    pushed_cnt        = 0;
    accepted_cnt      = 0;
    fail_cnt          = 0;
    cycle_cnt         = 0;
    cur_cell_size     = dcse_pkg::CELL_SIZE_RST;
    cur_cells_high    = dcse_pkg::CELLS_HIGH_RST;
    col_in_run        = 1'b0;
    col_run_bottom    = '0;
    col_prev_density  = '0;
    col_corner        = '0;

    // extremes, zero cell size, out-of-range cells_high (both ways), calm run
    phase_cell  = '{16'hffff, 16'h0001, 16'h0000, dcse_pkg::CELL_W'($urandom), 16'h0180,
                    dcse_pkg::CELL_W'($urandom_range(1, 16'hffff))};
    phase_cells = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd8,
                    dcse_pkg::CH_W'($urandom_range(1, MAX_CELLS))};

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset register values.
    // run from corner 0 closed on the top sample, extreme densities
    push_sample(DENS_MAX, 1'b0);
    push_sample(DENS_MIN, 1'b1);
    // run opened mid column, closed before the top; column ends in air
    push_sample(DENS_MIN, 1'b0);
    push_sample(DENS_MAX, 1'b0);
    push_sample(DENS_ONE, 1'b0);
    push_sample(DENS_ZERO, 1'b0);
    push_sample(DENS_NEG1, 1'b1);
    // all air: column end without span
    push_sample(DENS_ZERO, 1'b0);
    push_sample(DENS_ZERO, 1'b0);
    push_sample(DENS_ZERO, 1'b1);
    // single solid sample column: capped at the ceiling right away
    push_sample(16'd5, 1'b1);
    // open run capped at the ceiling
    push_sample(-16'sd5, 1'b0);
    push_sample(16'd10, 1'b0);
    push_sample(16'd20, 1'b0);
    push_sample(16'd30, 1'b1);
    // alternating: several spans in one column
    push_sample(DENS_ONE, 1'b0);
    push_sample(DENS_NEG1, 1'b0);
    push_sample(DENS_ONE, 1'b0);
    push_sample(DENS_NEG1, 1'b0);
    push_sample(DENS_ONE, 1'b1);
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(dcse_pkg::REG_CELL_SIZE, dcse_pkg::CFG_DATA_W'(phase_cell[p]));
      write_reg(dcse_pkg::REG_CELLS_HIGH, dcse_pkg::CFG_DATA_W'(phase_cells[p]));
      calm = (p == 4);
      random_columns(PHASE_ITEMS);
      wait_drained();   // sender holds off until every result is back
    end
    calm = 1'b0;

    repeat (TAIL) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
